>>> design/vbec_pkg.sv
package vbec_pkg;

    localparam int MAX_DIM   = 256;
    localparam int FRAC_BITS = 16;
    localparam int WF        = 24;
    localparam int ROUND_SH  = WF - FRAC_BITS;

    localparam int POS_W  = 8;
    localparam int SIZE_W = 9;
    localparam int STR_W  = 17;
    localparam int SEED_W = 16;
    localparam int DENS_W = 24;
    localparam int CFG_W  = 17;
    localparam int P_W    = 26;
    localparam int R_W    = 30;
    localparam int SIN_W  = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
    localparam logic [STR_W-1:0]  STR_ONE    = STR_W'(65536);

    localparam logic signed [47:0] K_X1 = 48'sd740557;
    localparam logic signed [47:0] K_Y1 = 48'sd465306;
    localparam logic signed [47:0] K_Z2 = 48'sd635699;
    localparam logic signed [47:0] K_Y2 = 48'sd347341;
    localparam logic signed [63:0] INV_TWO_PI_Q32 = 64'sd683565276;
    localparam logic [31:0]        K_PH2   = 32'd47841;
    localparam logic signed [43:0] K_ROUGH = 44'sd14418;
    localparam logic [21:0]        BASE_C0 = 22'd587203;
    localparam logic [37:0]        BASE_C1 = 38'd1090519;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [30:0] SIN_C1  = 31'd1686629713;
    localparam logic [30:0] SIN_C3  = 31'd693598668;
    localparam logic [30:0] SIN_C5  = 31'd85569306;
    localparam logic [30:0] SIN_C7  = 31'd5026995;

    typedef enum logic [2:0] {
        CFG_SIZE_X   = 3'd0,
        CFG_SIZE_Y   = 3'd1,
        CFG_SIZE_Z   = 3'd2,
        CFG_STRENGTH = 3'd3,
        CFG_SEED     = 3'd4
    } cfg_index_t;

    typedef logic [25:0] quot_tbl_t [256];
    typedef logic [7:0]  rem_tbl_t  [256];
    typedef logic [24:0] recip_tbl_t [256];

    typedef struct packed {
        logic [7:0]  d;
        logic [25:0] a;
        logic [7:0]  b;
        logic [24:0] m;
        logic [6:0]  h;
    } axis_cfg_t;

    // Shift and subtract division; the remainder sits above the quotient.
    function automatic logic [33:0] long_div(input logic [25:0] num, input logic [7:0] den);
        logic [25:0] q;
        logic [8:0]  r;
        q = '0;
        r = '0;
        for (int b = 25; b >= 0; b--) begin
            r = {r[7:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return {r[7:0], q};
    endfunction

    function automatic quot_tbl_t build_quot();
        quot_tbl_t   t;
        logic [33:0] qr;
        t[0] = '0;
        for (int i = 1; i < 256; i++) begin
            qr   = long_div(26'h200_0000, 8'(i));
            t[i] = qr[25:0];
        end
        return t;
    endfunction

    function automatic rem_tbl_t build_rem();
        rem_tbl_t    t;
        logic [33:0] qr;
        t[0] = '0;
        for (int i = 1; i < 256; i++) begin
            qr   = long_div(26'h200_0000, 8'(i));
            t[i] = qr[33:26];
        end
        return t;
    endfunction

    function automatic recip_tbl_t build_recip();
        recip_tbl_t  t;
        logic [33:0] qr;
        t[0] = '0;
        for (int i = 1; i < 256; i++) begin
            qr   = long_div(26'((1 << 24) + i - 1), 8'(i));
            t[i] = qr[24:0];
        end
        return t;
    endfunction

    localparam quot_tbl_t  QUOT_TBL  = build_quot();
    localparam rem_tbl_t   REM_TBL   = build_rem();
    localparam recip_tbl_t RECIP_TBL = build_recip();

    function automatic axis_cfg_t axis_cfg(input logic [SIZE_W-1:0] n);
        axis_cfg_t   c;
        logic [SIZE_W-1:0] nc;
        if (n < SIZE_W'(2)) begin
            nc = SIZE_W'(2);
        end else if (n > SIZE_W'(MAX_DIM)) begin
            nc = SIZE_W'(MAX_DIM);
        end else begin
            nc = n;
        end
        c.d = 8'(nc - SIZE_W'(1));
        c.a = QUOT_TBL[c.d];
        c.b = REM_TBL[c.d];
        c.m = RECIP_TBL[c.d];
        c.h = c.d[7:1];
        return c;
    endfunction

    function automatic logic [20:0] base_depth(input logic [STR_W-1:0] strength);
        logic [STR_W-1:0] s;
        logic [37:0]      prod;
        s    = (strength > STR_ONE) ? STR_ONE : strength;
        prod = BASE_C1 * {21'd0, s};
        return 21'(BASE_C0 + prod[37:16]);
    endfunction

endpackage

>>> design/vbec_coord.sv
module vbec_coord
    import vbec_pkg::*;
(
    input  logic                  aclk,
    input  logic                  en,
    input  logic [POS_W-1:0]      pos,
    input  axis_cfg_t             cfg,
    output logic signed [P_W-1:0] p,
    output logic                  face
);

    logic [7:0]     pc;
    logic [33:0]    pa_full;
    logic [15:0]    w_next;
    logic [25:0]    pa_reg;
    logic [15:0]    w_reg;
    logic           face_reg;
    logic [40:0]    wm;
    logic [25:0]    q;
    logic signed [P_W-1:0] p_reg;

    assign pc      = (pos > cfg.d) ? cfg.d : pos;
    assign pa_full = {26'd0, pc} * {8'd0, cfg.a};
    assign w_next  = 16'({8'd0, pc} * {8'd0, cfg.b}) + 16'(cfg.h);
    assign wm      = {25'd0, w_reg} * {16'd0, cfg.m};
    assign q       = pa_reg + 26'(wm[40:24]);

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg   <= pa_full[25:0];
            w_reg    <= w_next;
            face_reg <= (pc == 8'd0) || (pc == cfg.d);
            p_reg    <= signed'(q - 26'(1 << WF));
        end
    end

    assign p    = p_reg;
    assign face = face_reg;

endmodule

>>> design/vbec_sine.sv
module vbec_sine
    import vbec_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic [31:0]             angle,
    output logic signed [SIN_W-1:0] sine
);

    logic [1:0]  q_reg [0:4];
    logic [30:0] x_reg [0:4];
    logic [30:0] x2_reg [0:2];
    logic [30:0] t5_reg;
    logic [30:0] t3_reg;
    logic [30:0] t1_reg;
    logic signed [SIN_W-1:0] sine_reg;

    logic [30:0] x_next;
    logic [61:0] xx;
    logic [61:0] p7;
    logic [61:0] p5;
    logic [61:0] p3;
    logic [61:0] p1;
    logic [30:0] s_mag;

    assign x_next = angle[30] ? (Q30_ONE - {1'b0, angle[29:0]}) : {1'b0, angle[29:0]};
    assign xx     = {31'd0, x_reg[0]} * {31'd0, x_reg[0]};
    assign p7     = {31'd0, x2_reg[0]} * {31'd0, SIN_C7};
    assign p5     = {31'd0, x2_reg[1]} * {31'd0, t5_reg};
    assign p3     = {31'd0, x2_reg[2]} * {31'd0, t3_reg};
    assign p1     = {31'd0, x_reg[4]} * {31'd0, t1_reg};
    assign s_mag  = (p1[60:30] > Q30_ONE) ? Q30_ONE : p1[60:30];

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0]  <= angle[31:30];
            x_reg[0]  <= x_next;
            for (int i = 1; i < 5; i++) begin
                q_reg[i] <= q_reg[i-1];
                x_reg[i] <= x_reg[i-1];
            end
            x2_reg[0] <= xx[60:30];
            for (int i = 1; i < 3; i++) begin
                x2_reg[i] <= x2_reg[i-1];
            end
            t5_reg <= SIN_C5 - p7[60:30];
            t3_reg <= SIN_C3 - p5[60:30];
            t1_reg <= SIN_C1 - p3[60:30];
            sine_reg <= q_reg[4][1] ? -signed'({1'b0, s_mag}) : signed'({1'b0, s_mag});
        end
    end

    assign sine = sine_reg;

endmodule

>>> design/voxel_boundary_envelope_clamp_unit.sv
// Boundary envelope clamp for a stream of voxels.
// Each item on the slave channel is one voxel: its x, y and z coordinates and a
// signed Q7.16 density. Each item on the master channel is the clamped density,
// a flag that says whether the envelope replaced the input, and two flags that
// mark air on a face of the volume before and after the clamp.
// The volume extent, closure strength and phase seed are written through the
// configuration port while no item is in flight; each write lands in its register,
// from which the axis constants, base depth and seed phase are then registered.
// The datapath is a pipeline of fifteen register stages, and m_tvalid is the valid
// bit of the last stage. One item is taken in every cycle while the pipeline is
// not held; the depth is set by the chain of multiplications for the coordinate
// mapping, the seventh-order sine polynomial and the envelope product.
// When the receiver holds tready low with a result waiting, the whole pipeline
// holds and s_tready falls, so no item is lost or repeated.
// Reset clears all valid bits and loads the register defaults: a 64 cube, zero
// strength and zero seed, so that voxels pass through unchanged.
module voxel_boundary_envelope_clamp_unit
    import vbec_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, pos_z, density_in
    input  logic [47:0]       s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // density_out, changed, edge_air_before, edge_air_after, zero padding
    output logic [31:0]       m_tdata,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int LAT = 15;

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [STR_W-1:0]  strength_reg;
    logic [SEED_W-1:0] seed_reg;
    axis_cfg_t         cfg_x_reg, cfg_y_reg, cfg_z_reg;
    logic [20:0]       base_reg;
    logic [31:0]       seed2_reg;

    logic en;
    logic valid_reg [0:LAT-1];

    logic signed [P_W-1:0] px, py, pz;
    logic fx, fy, fz;

    logic signed [DENS_W-1:0] din_reg [0:13];
    logic face_reg [0:12];
    logic [24:0] inward_reg [0:10];

    logic [24:0] ax, ay, az, amax;
    logic signed [47:0] kx1_reg, ky1_reg, kz2_reg, ky2_reg;
    logic signed [47:0] sum1, sum2;
    logic signed [R_W-1:0] r1_reg, r2_reg;
    logic signed [63:0] t1p, t2p;
    logic [31:0] a1_reg, a2_reg;
    logic signed [SIN_W-1:0] s1, s2;
    logic signed [63:0] ss;
    logic signed [27:0] p12_reg;
    logic signed [43:0] rp;
    logic signed [27:0] rough_reg;
    logic signed [49:0] br;
    logic signed [25:0] brs;
    logic signed [26:0] env_reg;
    logic signed [27:0] er;
    logic signed [19:0] envr;
    logic signed [DENS_W-1:0] env24;
    logic signed [DENS_W-1:0] dout_next;
    logic changed_next;
    logic [31:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg   <= SIZE_RESET;
            size_y_reg   <= SIZE_RESET;
            size_z_reg   <= SIZE_RESET;
            strength_reg <= '0;
            seed_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_SIZE_X:   size_x_reg   <= cfg_wdata[SIZE_W-1:0];
                CFG_SIZE_Y:   size_y_reg   <= cfg_wdata[SIZE_W-1:0];
                CFG_SIZE_Z:   size_z_reg   <= cfg_wdata[SIZE_W-1:0];
                CFG_STRENGTH: strength_reg <= cfg_wdata[STR_W-1:0];
                CFG_SEED:     seed_reg     <= cfg_wdata[SEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_x_reg <= axis_cfg(SIZE_RESET);
            cfg_y_reg <= axis_cfg(SIZE_RESET);
            cfg_z_reg <= axis_cfg(SIZE_RESET);
            base_reg  <= base_depth('0);
            seed2_reg <= '0;
        end else begin
            cfg_x_reg <= axis_cfg(size_x_reg);
            cfg_y_reg <= axis_cfg(size_y_reg);
            cfg_z_reg <= axis_cfg(size_z_reg);
            base_reg  <= base_depth(strength_reg);
            seed2_reg <= {16'd0, seed_reg} * K_PH2;
        end
    end

    assign en       = m_tready || !valid_reg[LAT-1];
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    vbec_coord u_coord_x (
        .aclk (aclk), .en (en), .pos (s_tdata[7:0]),   .cfg (cfg_x_reg), .p (px), .face (fx)
    );
    vbec_coord u_coord_y (
        .aclk (aclk), .en (en), .pos (s_tdata[15:8]),  .cfg (cfg_y_reg), .p (py), .face (fy)
    );
    vbec_coord u_coord_z (
        .aclk (aclk), .en (en), .pos (s_tdata[23:16]), .cfg (cfg_z_reg), .p (pz), .face (fz)
    );

    assign ax   = 25'(px < 0 ? -px : px);
    assign ay   = 25'(py < 0 ? -py : py);
    assign az   = 25'(pz < 0 ? -pz : pz);
    assign amax = (ax >= ay) ? ((ax >= az) ? ax : az) : ((ay >= az) ? ay : az);

    assign sum1 = kx1_reg + ky1_reg;
    assign sum2 = kz2_reg - ky2_reg;
    assign t1p  = 64'(r1_reg) * INV_TWO_PI_Q32;
    assign t2p  = 64'(r2_reg) * INV_TWO_PI_Q32;

    vbec_sine u_sine_1 (.aclk (aclk), .en (en), .angle (a1_reg), .sine (s1));
    vbec_sine u_sine_2 (.aclk (aclk), .en (en), .angle (a2_reg), .sine (s2));

    assign ss  = 64'(s1) * 64'(s2);
    assign rp  = 44'(p12_reg) * K_ROUGH;
    assign br  = 50'(signed'({1'b0, base_reg})) * 50'(rough_reg);
    assign brs = br[49:24];
    assign er  = 28'(env_reg) + 28'sd128;
    assign envr  = er[27:ROUND_SH];
    assign env24 = DENS_W'(envr);

    always_comb begin
        dout_next    = din_reg[13];
        changed_next = 1'b0;
        if (strength_reg != '0 && env24 > din_reg[13]) begin
            dout_next    = env24;
            changed_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            din_reg[0] <= signed'(s_tdata[47:24]);
            for (int i = 1; i < 14; i++) begin
                din_reg[i] <= din_reg[i-1];
            end
            face_reg[0] <= fx || fy || fz;
            for (int i = 1; i < 13; i++) begin
                face_reg[i] <= face_reg[i-1];
            end
            inward_reg[0] <= 25'(1 << WF) - amax;
            for (int i = 1; i < 11; i++) begin
                inward_reg[i] <= inward_reg[i-1];
            end
            kx1_reg   <= 48'(px) * K_X1;
            ky1_reg   <= 48'(py) * K_Y1;
            kz2_reg   <= 48'(pz) * K_Z2;
            ky2_reg   <= 48'(py) * K_Y2;
            r1_reg    <= sum1[45:16];
            r2_reg    <= sum2[45:16];
            a1_reg    <= t1p[55:24] + {seed_reg, 16'd0};
            a2_reg    <= t2p[55:24] + seed2_reg;
            p12_reg   <= ss[63:36];
            rough_reg <= 28'(1 << WF) + rp[43:16];
            env_reg   <= 27'(brs) - 27'(signed'({2'b0, inward_reg[10]}));
            m_tdata_reg <= {5'd0,
                            face_reg[12] && dout_next[DENS_W-1],
                            face_reg[12] && din_reg[13][DENS_W-1],
                            changed_next,
                            dout_next};
        end
    end

    assign m_tvalid = valid_reg[LAT-1];
    assign m_tdata  = m_tdata_reg;

endmodule
